// File: sv/ip_in_ip_header_builder_top_assert.svh
// Assertion macros for the IP-in-IP header builder.
// Used by iihb_seq and ip_in_ip_header_builder_top; no other dependencies.
`ifndef IP_IN_IP_HEADER_BUILDER_TOP_ASSERT_SVH
`define IP_IN_IP_HEADER_BUILDER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("header builder check failed");
// Next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("header builder check failed");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: sv/iihb_pkg.sv
// Shared types and constants of the IP-in-IP outer header builder.
// No dependencies; imported by every module of the block.
package iihb_pkg;

   localparam int BINDING_ENTRIES_DEF = 16;

   // Request opcodes
   localparam logic OP_ENCAP = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Outer header constants
   localparam logic [7:0]  OUTER_VER_IHL   = 8'h45;
   localparam logic [7:0]  OUTER_TTL       = 8'd200;
   localparam logic [7:0]  OUTER_PROTOCOL  = 8'd4;
   localparam logic [16:0] OUTER_HDR_BYTES = 17'd20;
   localparam logic [15:0] LEN_MAX         = 16'hFFFF;

   // Header word positions
   localparam logic [2:0] WORD_LEN = 3'd0;
   localparam logic [2:0] WORD_ID  = 3'd1;
   localparam logic [2:0] WORD_TTL = 3'd2;
   localparam logic [2:0] WORD_SRC = 3'd3;
   localparam logic [2:0] WORD_DST = 3'd4;

   typedef struct packed {
      logic        opcode;
      logic [7:0]  inner_tos;
      logic [15:0] inner_length;
      logic [31:0] inner_destination;
      logic [3:0]  entry_index;
      logic [31:0] home_address;
      logic [31:0] care_of_address;
      logic        entry_valid;
   } req_type;

   typedef struct packed {
      logic [31:0] header_word;
      logic        last_word;
      logic        binding_found;
   } rsp_type;

   // Lookup transaction travelling down the binding chain
   typedef struct packed {
      logic        active;
      logic        found;
      logic [31:0] key;
      logic [31:0] dst;
   } token_type;

   // Encapsulate transaction handed to the sequencer at accept
   typedef struct packed {
      logic        go;
      logic [7:0]  tos;
      logic [15:0] length;
   } enc_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EMIT
   } seq_state_type;

endpackage

// File: sv/iihb_cell.sv
// One binding table slot: stores home/care-of/valid and checks the passing lookup.
// Depends on iihb_pkg.
module iihb_cell
   import iihb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [31:0] wr_home,
   input  logic [31:0] wr_care,
   input  logic        wr_valid,
   input  token_type   prev_tok,
   output token_type   next_tok
);

   logic [31:0] home_ff;
   logic [31:0] care_ff;
   logic        valid_ff;
   token_type   tok_ff;
   token_type   tok_in;
   logic        hit;

   // Update the slot on a write transaction
   always_ff @(posedge clock) begin
      if (wr_en) begin
         home_ff <= wr_home;
         care_ff <= wr_care;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff <= wr_valid;
      end
   end

   // Take the first valid match; later slots see found and pass it along
   assign hit = prev_tok.active && !prev_tok.found && valid_ff && (home_ff == prev_tok.key);

   always_comb begin
      tok_in = prev_tok;
      if (hit) begin
         tok_in.found = 1'b1;
         tok_in.dst   = care_ff;
      end
   end

   // Advance the lookup one slot
   always_ff @(posedge clock) begin
      tok_ff.found <= tok_in.found;
      tok_ff.key   <= tok_in.key;
      tok_ff.dst   <= tok_in.dst;
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff.active <= tok_in.active;
      end
   end

   assign next_tok = tok_ff;

endmodule

// File: sv/iihb_seq.sv
// Control sequencer and header formatter: checksum and five-word emission.
// Depends on iihb_pkg and ip_in_ip_header_builder_top_assert.svh.
`include "ip_in_ip_header_builder_top_assert.svh"
module iihb_seq
   import iihb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  enc_cmd_type cmd,
   input  token_type   tok_exit,
   input  logic [31:0] source_address,
   output logic        busy,
   output logic        rsp_strobe,
   output rsp_type     rsp_payload
);

   seq_state_type state_ff;
   seq_state_type state_in;
   logic [2:0]    cnt_ff;
   logic [2:0]    cnt_in;
   logic [7:0]    tos_ff;
   logic [15:0]   tlen_ff;
   logic [17:0]   part_ff;
   logic [18:0]   sum_ff;
   logic [31:0]   dst_ff;
   logic          found_ff;
   logic          rsp_strobe_ff;
   rsp_type       rsp_payload_ff;
   rsp_type       rsp_in;

   logic          emit_en;
   logic          load_sum;
   logic [16:0]   len_sum;
   logic [15:0]   len_sat;
   logic [16:0]   fold1;
   logic [15:0]   fold2;
   logic [15:0]   csum;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.go) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (tok_exit.active) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (cnt_ff == WORD_DST) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      emit_en  = 1'b0;
      load_sum = 1'b0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE:   busy = 1'b0;
         ST_LOOKUP: load_sum = tok_exit.active;
         ST_EMIT:   emit_en = 1'b1;
         default:   busy = 1'b1;
      endcase
   end

   assign cnt_in = emit_en ? cnt_ff + 3'd1 : WORD_LEN;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= WORD_LEN;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Saturate the outer length
   assign len_sum = {1'b0, cmd.length} + OUTER_HDR_BYTES;
   assign len_sat = len_sum[16] ? LEN_MAX : len_sum[15:0];

   // Capture fixed header fields and their partial checksum at accept
   always_ff @(posedge clock) begin
      if (cmd.go && (state_ff == ST_IDLE)) begin
         tos_ff  <= cmd.tos;
         tlen_ff <= len_sat;
         part_ff <= 18'({OUTER_VER_IHL, cmd.tos}) + 18'(len_sat)
                  + 18'({OUTER_TTL, OUTER_PROTOCOL});
      end
   end

   // Finish the sum once the lookup leaves the chain
   always_ff @(posedge clock) begin
      if (load_sum) begin
         dst_ff   <= tok_exit.dst;
         found_ff <= tok_exit.found;
         sum_ff   <= 19'(part_ff) + 19'(source_address[31:16]) + 19'(source_address[15:0])
                   + 19'(tok_exit.dst[31:16]) + 19'(tok_exit.dst[15:0]);
      end
   end

   // Fold carries back in and complement
   assign fold1 = {1'b0, sum_ff[15:0]} + 17'(sum_ff[18:16]);
   assign fold2 = fold1[15:0] + 16'(fold1[16]);
   assign csum  = ~fold2;

   // Select the word for this cycle
   always_comb begin
      rsp_in.last_word     = (cnt_ff == WORD_DST);
      rsp_in.binding_found = found_ff;
      unique case (cnt_ff)
         WORD_LEN: rsp_in.header_word = {OUTER_VER_IHL, tos_ff, tlen_ff};
         WORD_ID:  rsp_in.header_word = 32'd0;
         WORD_TTL: rsp_in.header_word = {OUTER_TTL, OUTER_PROTOCOL, csum};
         WORD_SRC: rsp_in.header_word = source_address;
         WORD_DST: rsp_in.header_word = dst_ff;
         default:  rsp_in.header_word = 32'd0;
      endcase
   end

   // Register the result transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= emit_en;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_en) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

   `ASSERT_NXT(a_words_contiguous, clock, reset, rsp_strobe_ff && !rsp_payload_ff.last_word, rsp_strobe_ff)
   `ASSERT_NXT(a_gap_after_last, clock, reset, rsp_strobe_ff && rsp_payload_ff.last_word, !rsp_strobe_ff)
   `ASSERT_IMP(a_exit_in_lookup, clock, reset, tok_exit.active, state_ff == ST_LOOKUP)

endmodule

// File: sv/ip_in_ip_header_builder_top.sv
// IP-in-IP outer header builder, top level: binding chain, source register, sequencer.
// Depends on iihb_pkg, iihb_cell, iihb_seq and ip_in_ip_header_builder_top_assert.svh.
//
// Usage:
//  - Request: a transaction is taken at a clock edge with start high and busy low.
//    opcode OP_WRITE updates one binding slot in that edge and returns nothing;
//    busy stays low, so the next request may follow in the next cycle.
//  - opcode OP_ENCAP sends the inner destination down a row of BINDING_ENTRIES
//    slot cells, one cell per cycle; the lowest matching valid slot supplies
//    the care-of address.
//  - Response: five header words, one per cycle, each marked by rsp_strobe for
//    one cycle; last_word flags the fifth. The first word is registered once the
//    lookup has left the last slot cell and the sequencer has finished the sum.
//  - Busy: after an encapsulate accept, busy stays high while the lookup walks
//    the slot chain and the five words are emitted; no new request is taken until then.
//  - csr: csr_ready is always high; write source_address only while busy is low.
//  - Reset (synchronous, active high) empties the table and clears
//    source_address. The receiver cannot stall, so nothing is held back.
`include "ip_in_ip_header_builder_top_assert.svh"
module ip_in_ip_header_builder_top
   import iihb_pkg::*;
#(
   parameter int BINDING_ENTRIES = BINDING_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_strobe,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   logic        accept;
   logic        wr_req;
   logic [31:0] source_address_ff;
   token_type   chain_tok [BINDING_ENTRIES+1];
   logic [BINDING_ENTRIES-1:0] chain_active;
   enc_cmd_type cmd;

   assign accept = start && !busy;
   assign wr_req = accept && (req_payload.opcode == OP_WRITE);

   // Hold the source address register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_address_ff <= 32'd0;
      end else if (csr_valid && csr_ready) begin
         source_address_ff <= csr_data;
      end
   end

   // Launch a lookup into the head of the chain
   always_comb begin
      chain_tok[0].active = accept && (req_payload.opcode == OP_ENCAP);
      chain_tok[0].found  = 1'b0;
      chain_tok[0].key    = req_payload.inner_destination;
      chain_tok[0].dst    = req_payload.inner_destination;
   end

   // Row of binding slot cells
   for (genvar i = 0; i < BINDING_ENTRIES; i++) begin : g_cell
      logic cell_wr;

      assign cell_wr = wr_req && (int'(req_payload.entry_index) == i);
      assign chain_active[i] = chain_tok[i+1].active;

      iihb_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (cell_wr),
         .wr_home  (req_payload.home_address),
         .wr_care  (req_payload.care_of_address),
         .wr_valid (req_payload.entry_valid),
         .prev_tok (chain_tok[i]),
         .next_tok (chain_tok[i+1])
      );
   end

   assign cmd.go     = chain_tok[0].active;
   assign cmd.tos    = req_payload.inner_tos;
   assign cmd.length = req_payload.inner_length;

   iihb_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .tok_exit       (chain_tok[BINDING_ENTRIES]),
      .source_address (source_address_ff),
      .busy           (busy),
      .rsp_strobe     (rsp_strobe),
      .rsp_payload    (rsp_payload)
   );

   `ASSERT_IMP(a_one_lookup, clock, reset, 1'b1, $onehot0(chain_active))
   `ASSERT_NXT(a_busy_after_encap, clock, reset, cmd.go, busy)

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the IP-in-IP outer header builder.
// Depends on iihb_pkg and ip_in_ip_header_builder_top; predicts every header word
// from its own binding table copy and checks each strobed word in order.
module tb_top;
   import iihb_pkg::*;

   localparam int          ENTRIES      = 16;
   localparam int          DRAIN_CYCLES = 2 * ENTRIES + 12;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          REPORT_MAX   = 10;
   localparam logic [7:0]  HDR_VER_IHL  = 8'h45;
   localparam logic [7:0]  HDR_TTL      = 8'd200;
   localparam logic [7:0]  HDR_PROTO    = 8'd4;
   localparam logic [16:0] HDR_BYTES    = 17'd20;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_payload;
   logic        rsp_strobe;
   rsp_type     rsp_payload;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   // Predictor state: binding table and source register
   logic [31:0] slot_home    [ENTRIES];
   logic [31:0] slot_care_of [ENTRIES];
   logic        slot_valid   [ENTRIES];
   logic [31:0] source_addr;
   logic [31:0] home_pool    [8];

   rsp_type     expected_words[$];
   int          mismatch_count;
   int          cycle_count;
   int          sender_idle_pct;

   ip_in_ip_header_builder_top dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bound the run; a hung handshake ends here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   // Apply a binding write to the predicted table
   function automatic void store_binding(input req_type item);
      if (int'(item.entry_index) < ENTRIES) begin
         slot_home[item.entry_index]    = item.home_address;
         slot_care_of[item.entry_index] = item.care_of_address;
         slot_valid[item.entry_index]   = item.entry_valid;
      end
   endfunction

   // Compute the five outer header words of one encapsulate transaction
   function automatic void build_outer_header(input req_type item);
      logic [31:0] word [5];
      logic [31:0] dst;
      logic        hit;
      logic [16:0] total;
      logic [31:0] sum;
      rsp_type     rsp;
      dst = item.inner_destination;
      hit = 1'b0;
      // lowest valid matching slot wins
      for (int i = 0; i < ENTRIES; i++) begin
         if (!hit && slot_valid[i] && slot_home[i] == item.inner_destination) begin
            hit = 1'b1;
            dst = slot_care_of[i];
         end
      end
      total   = {1'b0, item.inner_length} + HDR_BYTES;
      word[0] = {HDR_VER_IHL, item.inner_tos, total[16] ? 16'hFFFF : total[15:0]};
      word[1] = '0;
      word[2] = {HDR_TTL, HDR_PROTO, 16'h0000};
      word[3] = source_addr;
      word[4] = dst;
      // fold the halfword sum twice, then complement
      sum = '0;
      for (int i = 0; i < 5; i++) sum += word[i][31:16] + word[i][15:0];
      sum = sum[15:0] + sum[31:16];
      sum = sum[15:0] + sum[31:16];
      word[2][15:0] = ~sum[15:0];
      for (int i = 0; i < 5; i++) begin
         rsp.header_word   = word[i];
         rsp.last_word     = (i == 4);
         rsp.binding_found = hit;
         expected_words.push_back(rsp);
      end
   endfunction

   // Fill every field at random; the opcode decides which ones matter
   function automatic req_type random_fields();
      req_type item;
      item.opcode            = 1'($urandom_range(1, 0));
      item.inner_tos         = 8'($urandom);
      item.inner_length      = 16'($urandom);
      item.inner_destination = $urandom;
      item.entry_index       = 4'($urandom);
      item.home_address      = $urandom;
      item.care_of_address   = $urandom;
      item.entry_valid       = 1'($urandom_range(1, 0));
      return item;
   endfunction

   function automatic req_type encap_item(input logic [7:0] tos, input logic [15:0] len,
                                          input logic [31:0] dst);
      req_type item;
      item                   = random_fields();
      item.opcode            = OP_ENCAP;
      item.inner_tos         = tos;
      item.inner_length      = len;
      item.inner_destination = dst;
      return item;
   endfunction

   function automatic req_type binding_item(input logic [3:0] slot, input logic [31:0] home,
                                            input logic [31:0] coa, input logic valid);
      req_type item;
      item                 = random_fields();
      item.opcode          = OP_WRITE;
      item.entry_index     = slot;
      item.home_address    = home;
      item.care_of_address = coa;
      item.entry_valid     = valid;
      return item;
   endfunction

   // Send one transaction, with a random gap first; start stays high on return
   task automatic send_item(input req_type item);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (item.opcode == OP_WRITE) store_binding(item);
      else build_outer_header(item);
   endtask

   // Hold off until every predicted word has arrived and the block has drained
   task automatic wait_idle();
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the source register; call only while idle
   task automatic set_source(input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      source_addr = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("%s: expected word %h last %b found %b, got word %h last %b found %b",
                  what, want.header_word, want.last_word, want.binding_found,
                  got.header_word, got.last_word, got.binding_found);
   endtask

   // Check each strobed word against the oldest prediction
   always @(posedge clock) begin : check_words
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_words.size() == 0) begin
            note_mismatch("unexpected header word", '0, rsp_payload);
         end else begin
            want = expected_words.pop_front();
            if (rsp_payload.header_word !== want.header_word ||
                rsp_payload.last_word !== want.last_word ||
                rsp_payload.binding_found !== want.binding_found)
               note_mismatch("header word mismatch", want, rsp_payload);
         end
      end
   end

   // Length saturation, TOS and destination extremes on an empty table
   task automatic test_header_fields();
      set_source(32'hFFFF_FFFF);
      send_item(encap_item(8'h00, 16'd0, 32'h0000_0000));
      send_item(encap_item(8'hFF, 16'd65515, 32'hFFFF_FFFF));
      send_item(encap_item(8'hA5, 16'd65516, 32'h0A00_0001));
      send_item(encap_item(8'h5A, 16'hFFFF, $urandom));
      send_item(encap_item(8'h01, 16'd1, 32'hC0A8_0001));
      wait_idle();
   endtask

   // First match wins, invalid slots never match, removal falls through
   task automatic test_binding_lookup();
      logic [31:0] home_a;
      logic [31:0] home_b;
      logic [31:0] home_c;
      home_a = 32'h0A01_0101;
      home_b = 32'hFFFF_FFFF;
      home_c = 32'h0000_0000;
      send_item(binding_item(4'd0, home_a, 32'hC0DE_0000, 1'b1));
      send_item(binding_item(4'd15, home_b, 32'h1234_5678, 1'b1));
      send_item(encap_item(8'($urandom), 16'($urandom), home_a));
      send_item(encap_item(8'($urandom), 16'($urandom), home_b));
      // stored match in an invalid slot must miss
      send_item(binding_item(4'd3, home_c, 32'hDEAD_BEEF, 1'b0));
      send_item(encap_item(8'($urandom), 16'($urandom), home_c));
      // duplicate home in a lower slot takes over
      send_item(binding_item(4'd9, home_b, 32'h8765_4321, 1'b1));
      send_item(encap_item(8'($urandom), 16'($urandom), home_b));
      // pause until all words are back, then remove the lower slot
      wait_idle();
      send_item(binding_item(4'd9, home_b, 32'h0000_0000, 1'b0));
      send_item(encap_item(8'($urandom), 16'($urandom), home_b));
      send_item(encap_item(8'($urandom), 16'($urandom), 32'h0A01_0102));
      wait_idle();
   endtask

   // Source field follows each register write
   task automatic test_source_register();
      set_source(32'h0000_0000);
      send_item(encap_item(8'($urandom), 16'($urandom), home_pool[2]));
      wait_idle();
      set_source($urandom);
      send_item(encap_item(8'($urandom), 16'($urandom), 32'h0A01_0101));
      wait_idle();
   endtask

   // Mixed binding writes and lookups, keys drawn mostly from a small pool
   task automatic test_random_traffic(input int count);
      req_type     item;
      logic [31:0] dst;
      logic [15:0] len;
      int          pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99, 0);
         if (pick < 30) begin
            item = binding_item(4'($urandom),
                                ($urandom_range(99, 0) < 75) ? home_pool[$urandom_range(7, 0)]
                                                              : $urandom,
                                $urandom, $urandom_range(99, 0) < 75);
         end else begin
            pick = $urandom_range(99, 0);
            if (pick < 60) dst = home_pool[$urandom_range(7, 0)];
            else if (pick < 70) dst = slot_home[$urandom_range(ENTRIES - 1, 0)];
            else dst = $urandom;
            len  = ($urandom_range(99, 0) < 15) ? 16'($urandom_range(65535, 65490))
                                                : 16'($urandom);
            item = encap_item(8'($urandom), len, dst);
         end
         send_item(item);
      end
   endtask

   initial begin
      start          <= 1'b0;
      req_payload    <= '0;
      csr_valid      <= 1'b0;
      csr_data       <= '0;
      reset          <= 1'b1;
      mismatch_count  = 0;
      cycle_count     = 0;
      sender_idle_pct = 0;
      source_addr     = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_home[i]    = '0;
         slot_care_of[i] = '0;
         slot_valid[i]   = 1'b0;
      end
      home_pool[0] = 32'h0000_0000;
      home_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++) home_pool[i] = $urandom;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_header_fields();
      test_binding_lookup();
      test_source_register();

      // back to back, no gaps
      sender_idle_pct = 0;
      set_source($urandom);
      test_random_traffic(160);
      wait_idle();
      // sparse sender
      sender_idle_pct = 86;
      set_source(32'hFFFF_FFFF);
      test_random_traffic(150);
      wait_idle();
      // results cannot be held off, so only the sender idles here
      sender_idle_pct = 37;
      set_source($urandom);
      test_random_traffic(150);
      wait_idle();

      if (expected_words.size() != 0) begin
         $display("%0d header words never arrived", expected_words.size());
         mismatch_count += expected_words.size();
      end
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+sv
sv/iihb_pkg.sv
sv/iihb_cell.sv
sv/iihb_seq.sv
sv/ip_in_ip_header_builder_top.sv
test/tb_top.sv
